// ===== sv/sri_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sri_pkg
// Shared types and defaults for the segment versus rectangle hit test.
// ----------------------------------------------------------------------------
package sri_pkg;

  // Default coordinate width
  localparam int COORD_BITS_DEF = 16;

  // Result payload width on the output stream
  localparam int OUT_TDATA_W = 8;

  // Per-stage load enables from the pipeline control
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

endpackage

// ===== sv/sri_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sri_prep
// Stage 1: unpack the query and form the direction and offset terms.
// ----------------------------------------------------------------------------
module sri_prep
  import sri_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int IN_W       = 128,
  parameter int OW         = COORD_BITS + 2
) (
  input  logic                 clk,
  input  pipe_en_t             en,
  input  logic [IN_W-1:0]      in_tdata,
  output logic signed [OW-1:0] dxs_r,
  output logic signed [OW-1:0] dys_r,
  output logic signed [OW-1:0] ox_l_r,
  output logic signed [OW-1:0] ox_r_r,
  output logic signed [OW-1:0] oy_t_r,
  output logic signed [OW-1:0] oy_b_r,
  output logic signed [OW-1:0] w_r,
  output logic signed [OW-1:0] h_r
);

  localparam int N = COORD_BITS;

  logic signed [OW-1:0] x0, y0, x1, y1, rx, ry, rw, rh, rx2, ry2;

  // Unpack the fields: coordinates sign-extended, width and height zero-extended
  always_comb begin
    x0  = OW'(signed'(in_tdata[0*N +: N]));
    y0  = OW'(signed'(in_tdata[1*N +: N]));
    x1  = OW'(signed'(in_tdata[2*N +: N]));
    y1  = OW'(signed'(in_tdata[3*N +: N]));
    rx  = OW'(signed'(in_tdata[4*N +: N]));
    ry  = OW'(signed'(in_tdata[5*N +: N]));
    rw  = signed'({3'b000, in_tdata[6*N +: N-1]});
    rh  = signed'({3'b000, in_tdata[7*N-1 +: N-1]});
    rx2 = rx + rw;
    ry2 = ry + rh;
  end

  // Register the differences and the rectangle size
  always_ff @(posedge clk) begin
    if (en.s1) begin
      dxs_r  <= x1 - x0;
      dys_r  <= y1 - y0;
      ox_l_r <= rx - x0;
      ox_r_r <= rx2 - x0;
      oy_t_r <= ry - y0;
      oy_b_r <= ry2 - y0;
      w_r    <= rw;
      h_r    <= rh;
    end
  end

endmodule

// ===== sv/sri_edge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sri_edge
// Stages 2 to 4 for one edge: products, numerator, range compare.
// Hit when d != 0 and na/d, nb/d both lie in [0,1], checked without division.
// ----------------------------------------------------------------------------
module sri_edge
  import sri_pkg::*;
#(
  parameter int OW = COORD_BITS_DEF + 2
) (
  input  logic                 clk,
  input  pipe_en_t             en,
  input  logic signed [OW-1:0] da,
  input  logic signed [OW-1:0] db,
  input  logic signed [OW-1:0] pa,
  input  logic signed [OW-1:0] pb,
  input  logic signed [OW-1:0] qa,
  input  logic signed [OW-1:0] qb,
  input  logic signed [OW-1:0] ra,
  input  logic signed [OW-1:0] rb,
  output logic                 hit_r
);

  localparam int PW = 2 * OW;
  localparam int W  = PW + 1;

  logic signed [PW-1:0] pd_r, pp_r, pq_r, pn_r;
  logic signed [W-1:0]  d_r, na_r, nb_r;
  logic signed [W-1:0]  na_nxt;
  logic                 pos_ok, neg_ok, hit_nxt;

  // Stage 2: products
  always_ff @(posedge clk) begin
    if (en.s2) begin
      pd_r <= da * db;
      pp_r <= pa * pb;
      pq_r <= qa * qb;
      pn_r <= ra * rb;
    end
  end

  // Stage 3: numerator difference
  assign na_nxt = W'(pp_r) - W'(pq_r);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      d_r  <= W'(pd_r);
      na_r <= na_nxt;
      nb_r <= W'(pn_r);
    end
  end

  // Stage 4: range check on the sign of the denominator
  always_comb begin
    pos_ok  = !na_r[W-1] && !nb_r[W-1] && (na_r <= d_r) && (nb_r <= d_r);
    neg_ok  = (na_r[W-1] || (na_r == 0)) && (nb_r[W-1] || (nb_r == 0)) &&
              (na_r >= d_r) && (nb_r >= d_r);
    hit_nxt = (d_r != 0) && (d_r[W-1] ? neg_ok : pos_ok);
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      hit_r <= hit_nxt;
    end
  end

endmodule

// ===== sv/segment_rectangle_intersect.sv =====
`timescale 1ns / 1ps
// Pipeline: 4 work stages plus the output register lie between an input
// transfer and out_tvalid.
// Throughput: one query per cycle; each stage holds when the next is full and
// stalled, and bubbles close up.
// Reset: synchronous, active low; clears all valid bits, payload is not reset.
// ----------------------------------------------------------------------------
// segment_rectangle_intersect
// Streaming segment versus axis-aligned rectangle hit test, left, right, top and bottom edges.
// ----------------------------------------------------------------------------
module segment_rectangle_intersect
  import sri_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // seg_start_x, seg_start_y, seg_end_x, seg_end_y, rect_x, rect_y,
  // rect_width, rect_height, zero fill (lowest bit up)
  input  logic [((8*COORD_BITS-2+7)/8)*8-1:0]   in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // hit, left_hit, right_hit, top_hit, bottom_hit, zero fill (lowest bit up)
  output logic [OUT_TDATA_W-1:0]                out_tdata
);

  localparam int IN_W = ((8*COORD_BITS-2+7)/8)*8;
  localparam int OW   = COORD_BITS + 2;

  logic                 v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic                 rdy1, rdy2, rdy3, rdy4, rdy_out;
  pipe_en_t             en;
  logic signed [OW-1:0] dxs, dys, ox_l, ox_r, oy_t, oy_b, w, h;
  logic                 l_hit, r_hit, t_hit, b_hit;
  logic [4:0]           res_r;

  // Stage ready chain: a stage loads when empty or when its successor loads
  always_comb begin
    rdy_out = !out_valid_r || out_tready;
    rdy4    = !v4_r || rdy_out;
    rdy3    = !v3_r || rdy4;
    rdy2    = !v2_r || rdy3;
    rdy1    = !v1_r || rdy2;
    en.s1   = rdy1;
    en.s2   = rdy2;
    en.s3   = rdy3;
    en.s4   = rdy4;
  end

  assign in_tready = rdy1;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1)    v1_r        <= in_tvalid;
      if (rdy2)    v2_r        <= v1_r;
      if (rdy3)    v3_r        <= v2_r;
      if (rdy4)    v4_r        <= v3_r;
      if (rdy_out) out_valid_r <= v4_r;
    end
  end

  sri_prep #(
    .COORD_BITS (COORD_BITS),
    .IN_W       (IN_W),
    .OW         (OW)
  ) u_prep (
    .clk      (clk),
    .en       (en),
    .in_tdata (in_tdata),
    .dxs_r    (dxs),
    .dys_r    (dys),
    .ox_l_r   (ox_l),
    .ox_r_r   (ox_r),
    .oy_t_r   (oy_t),
    .oy_b_r   (oy_b),
    .w_r      (w),
    .h_r      (h)
  );

  // Vertical edges: terms negated as a set, which keeps both ratios
  sri_edge #(.OW(OW)) u_left (
    .clk (clk), .en (en),
    .da (dxs), .db (h), .pa (dys), .pb (ox_l), .qa (dxs), .qb (oy_t),
    .ra (h), .rb (ox_l), .hit_r (l_hit)
  );

  sri_edge #(.OW(OW)) u_right (
    .clk (clk), .en (en),
    .da (dxs), .db (h), .pa (dys), .pb (ox_r), .qa (dxs), .qb (oy_t),
    .ra (h), .rb (ox_r), .hit_r (r_hit)
  );

  // Horizontal edges
  sri_edge #(.OW(OW)) u_top (
    .clk (clk), .en (en),
    .da (dys), .db (w), .pa (dxs), .pb (oy_t), .qa (dys), .qb (ox_l),
    .ra (w), .rb (oy_t), .hit_r (t_hit)
  );

  sri_edge #(.OW(OW)) u_bottom (
    .clk (clk), .en (en),
    .da (dys), .db (w), .pa (dxs), .pb (oy_b), .qa (dys), .qb (ox_l),
    .ra (w), .rb (oy_b), .hit_r (b_hit)
  );

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rdy_out) begin
      res_r <= {b_hit, t_hit, r_hit, l_hit, l_hit | r_hit | t_hit | b_hit};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-5){1'b0}}, res_r};

endmodule

// ===== sim/sri_hit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sri_hit_checker
// Watches both stream channels of the segment versus rectangle hit test.
// Predicts the edge flags of every accepted query, compares each accepted
// result against the oldest prediction, and counts mismatches.
// ----------------------------------------------------------------------------
module sri_hit_checker
  import sri_pkg::*;
#(
  parameter int IN_W = 128
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_W-1:0]        in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     fail_count,
  output int                     pending,
  output int                     results_checked,
  output int                     hits_checked
);

  // Ring of predicted result words, far deeper than the pipeline can hold
  localparam int EXP_DEPTH = 2048;

  // Predicted result words, oldest at rd_count
  logic [OUT_TDATA_W-1:0] expected_flags [EXP_DEPTH];
  int wr_count = 0;
  int rd_count = 0;

  string flag_name [5] = '{"hit", "left_hit", "right_hit", "top_hit", "bottom_hit"};

  int mismatches  = 0;
  int outstanding = 0;
  int checked     = 0;
  int hit_results = 0;

  assign fail_count      = mismatches;
  assign pending         = outstanding;
  assign results_checked = checked;
  assign hits_checked    = hit_results;

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Parametric segment test against one rectangle edge, exact in 64 bits
  function automatic bit edge_crossed(input longint sx0, input longint sy0,
                                      input longint sx1, input longint sy1,
                                      input longint ex0, input longint ey0,
                                      input longint ex1, input longint ey1);
    longint dxs, dys, dxe, dye, ox, oy, den, num_s, num_e;
    dxs   = sx1 - sx0;
    dys   = sy1 - sy0;
    dxe   = ex1 - ex0;
    dye   = ey1 - ey0;
    ox    = ex0 - sx0;
    oy    = ey0 - sy0;
    den   = dys * dxe - dxs * dye;
    num_s = dxs * oy - dys * ox;
    num_e = dxe * oy - dye * ox;
    // Parallel, collinear or zero-length edges never count
    if (den == 0) return 1'b0;
    if (den < 0) begin
      den   = -den;
      num_s = -num_s;
      num_e = -num_e;
    end
    return (num_s >= 0) && (num_e >= 0) && (num_s <= den) && (num_e <= den);
  endfunction

  // Unpack one query and work out the result word
  function automatic logic [OUT_TDATA_W-1:0] predict_edge_hits(input logic [IN_W-1:0] q);
    longint x0, y0, x1, y1, rx, ry, rx2, ry2;
    logic   l, r, t, b;
    logic [OUT_TDATA_W-1:0] flags;
    x0  = $signed(q[15:0]);
    y0  = $signed(q[31:16]);
    x1  = $signed(q[47:32]);
    y1  = $signed(q[63:48]);
    rx  = $signed(q[79:64]);
    ry  = $signed(q[95:80]);
    rx2 = rx + longint'(q[110:96]);
    ry2 = ry + longint'(q[125:111]);
    l = edge_crossed(x0, y0, x1, y1, rx,  ry,  rx,  ry2);
    r = edge_crossed(x0, y0, x1, y1, rx2, ry,  rx2, ry2);
    t = edge_crossed(x0, y0, x1, y1, rx,  ry,  rx2, ry);
    b = edge_crossed(x0, y0, x1, y1, rx,  ry2, rx2, ry2);
    flags    = '0;
    flags[0] = l | r | t | b;
    flags[1] = l;
    flags[2] = r;
    flags[3] = t;
    flags[4] = b;
    return flags;
  endfunction

  // Predict on every input transfer, compare on every output transfer
  always @(posedge clk) begin
    logic [OUT_TDATA_W-1:0] want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_flags[wr_count % EXP_DEPTH] = predict_edge_hits(in_tdata);
        wr_count++;
      end
      if (out_tvalid && out_tready) begin
        if (wr_count == rd_count) begin
          report_mismatch($sformatf("result %02h with no query outstanding", out_tdata));
        end else begin
          want = expected_flags[rd_count % EXP_DEPTH];
          rd_count++;
          for (int i = 0; i < 5; i++) begin
            if (out_tdata[i] !== want[i]) begin
              report_mismatch($sformatf("result %0d: %s expected %0b got %0b",
                                        checked, flag_name[i], want[i], out_tdata[i]));
            end
          end
          if (out_tdata[OUT_TDATA_W-1:5] !== want[OUT_TDATA_W-1:5]) begin
            report_mismatch($sformatf("result %0d: fill bits expected 0 got %0b",
                                      checked, out_tdata[OUT_TDATA_W-1:5]));
          end
          checked     <= checked + 1;
          hit_results <= hit_results + int'(want[0]);
        end
      end
      outstanding <= wr_count - rd_count;
    end
  end

endmodule

// ===== sim/segment_rectangle_intersect_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_rectangle_intersect_test
// Drives directed and random segment/rectangle queries into the hit test
// under several handshake patterns, including a long output hold-off, and
// reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module segment_rectangle_intersect_test;
  import sri_pkg::*;

  localparam int IN_W           = ((8*COORD_BITS_DEF-2+7)/8)*8;
  localparam int RESET_CYCLES   = 9;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int CYCLE_LIMIT    = 400000;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_W-1:0]        in_tdata  = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int fail_count;
  int pending;
  int results_checked;
  int hits_checked;

  int tx_idle_pct      = 0;
  int rx_stall_pct     = 0;
  int holdoff_requests = 0;
  int holdoffs_served  = 0;
  int cycle_count      = 0;
  int queries_sent     = 0;
  int directed_count   = 0;

  segment_rectangle_intersect dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  sri_hit_checker #(
    .IN_W (IN_W)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .hits_checked    (hits_checked)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("** segment_rectangle_intersect: FAILED **");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (holdoff_requests != holdoffs_served) begin
        holdoffs_served++;
        out_tready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end
      out_tready <= (rx_stall_pct == 0) || ($urandom_range(99, 0) >= rx_stall_pct);
    end
  end

  // Pack fields lowest bit up, zero fill on top
  function automatic logic [IN_W-1:0] pack_query(input int sx, input int sy,
                                                 input int ex, input int ey,
                                                 input int rx, input int ry,
                                                 input int w,  input int h);
    return {2'b00, 15'(h), 15'(w), 16'(ry), 16'(rx), 16'(ey), 16'(ex), 16'(sy), 16'(sx)};
  endfunction

  // Mostly geometry near the rectangle so that edges are actually crossed
  function automatic logic [IN_W-1:0] random_query();
    int mode, cx, cy, w, h, sx, sy, ex, ey, tmp;
    mode = $urandom_range(99, 0);
    cx   = int'($urandom_range(64000, 0)) - 32000;
    cy   = int'($urandom_range(64000, 0)) - 32000;
    w    = $urandom_range(300, 0);
    h    = $urandom_range(300, 0);
    sx   = cx + int'($urandom_range(w + 500, 0)) - 250;
    sy   = cy + int'($urandom_range(h + 500, 0)) - 250;
    ex   = cx + int'($urandom_range(w + 500, 0)) - 250;
    ey   = cy + int'($urandom_range(h + 500, 0)) - 250;
    if (mode < 45) begin
      // local segment around the rectangle, kept as drawn
    end else if (mode < 65) begin
      // noise over the whole field range
      return pack_query($urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom);
    end else if (mode < 80) begin
      // one endpoint exactly on an edge or corner
      case ($urandom_range(3, 0))
        0: begin
          sx = cx;
          sy = cy + int'($urandom_range(h, 0));
        end
        1: begin
          sx = cx + w;
          sy = cy + int'($urandom_range(h, 0));
        end
        2: begin
          sx = cx + int'($urandom_range(w, 0));
          sy = cy;
        end
        default: begin
          sx = cx + int'($urandom_range(w, 0));
          sy = cy + h;
        end
      endcase
      if ($urandom_range(1, 0) == 1) begin
        tmp = sx; sx = ex; ex = tmp;
        tmp = sy; sy = ey; ey = tmp;
      end
    end else if (mode < 90) begin
      // axis-aligned segment, often collinear with an edge
      if ($urandom_range(1, 0) == 1) begin
        case ($urandom_range(2, 0))
          0:       sy = cy;
          1:       sy = cy + h;
          default: ;
        endcase
        ey = sy;
      end else begin
        case ($urandom_range(2, 0))
          0:       sx = cx;
          1:       sx = cx + w;
          default: ;
        endcase
        ex = sx;
      end
    end else begin
      // point segments and flat rectangles
      if ($urandom_range(1, 0) == 1) begin
        ex = sx;
        ey = sy;
      end
      if ($urandom_range(1, 0) == 1) w = 0;
      if ($urandom_range(1, 0) == 1) h = 0;
    end
    return pack_query(sx, sy, ex, ey, cx, cy, w, h);
  endfunction

  // Offer one query, with random idle cycles ahead of it
  task automatic push_query(input logic [IN_W-1:0] q);
    while (tx_idle_pct != 0 && $urandom_range(99, 0) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= q;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    queries_sent++;
  endtask

  task automatic run_phase(input int count, input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_stall_pct <= rx_pct;
    repeat (count) push_query(random_query());
  endtask

  // Hold until every predicted result has come back
  task automatic wait_for_drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: crossings, misses, touching, degenerate and extreme geometry
    push_query(pack_query(-10, 5, 20, 5, 0, 0, 10, 10));
    push_query(pack_query(5, -10, 5, 20, 0, 0, 10, 10));
    push_query(pack_query(-5, -5, 15, 15, 0, 0, 10, 10));
    push_query(pack_query(2, 2, 8, 8, 0, 0, 10, 10));
    push_query(pack_query(20, 20, 30, 25, 0, 0, 10, 10));
    push_query(pack_query(-5, 0, 15, 0, 0, 0, 10, 10));
    push_query(pack_query(-5, 5, 0, 5, 0, 0, 10, 10));
    push_query(pack_query(10, 5, 20, 5, 0, 0, 10, 10));
    push_query(pack_query(-5, 5, 5, 5, 0, 0, 0, 10));
    push_query(pack_query(5, -5, 5, 5, 0, 0, 10, 0));
    push_query(pack_query(3, 3, 3, 3, 0, 0, 10, 10));
    push_query(pack_query(-5, -5, 0, 0, 0, 0, 10, 10));
    push_query(pack_query(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
    push_query(pack_query(-32768, 32767, 32767, -32768, 0, 0, 32767, 32767));
    push_query(pack_query(32767, -32768, 32767, 32767, 32767, 32767, 32767, 32767));
    push_query(pack_query(-1, -1, -1, -1, -1, -1, 32767, 32767));
    push_query(pack_query(0, 0, 0, 0, 0, 0, 0, 0));
    push_query(pack_query(-32768, 0, 32767, 0, -100, -100, 0, 0));
    push_query(pack_query(0, -32768, 0, 32767, -16384, -16384, 32767, 32767));
    push_query(pack_query(100, -50, -50, 100, 0, 0, 50, 50));
    directed_count = queries_sent;

    // Random traffic, back to back
    run_phase(300, 0, 0);

    // Long output hold-off while the sender keeps pushing, then drain fully
    holdoff_requests <= holdoff_requests + 1;
    run_phase(40, 0, 0);
    in_tvalid <= 1'b0;
    wait_for_drain();

    run_phase(260, 81, 0);
    run_phase(260, 0, 81);
    run_phase(260, 10, 10);
    run_phase(220, 0, 0);
    in_tvalid    <= 1'b0;
    rx_stall_pct <= 0;

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d directed and %0d random queries over six handshake phases",
             directed_count, queries_sent - directed_count);
    $display("Checked %0d results, %0d of them with an edge crossed",
             results_checked, hits_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("** segment_rectangle_intersect: PASSED **");
    end else begin
      $display("** segment_rectangle_intersect: FAILED **");
    end
    $finish;
  end

endmodule
